>>> src/gebp_pkg.sv
// Shared types and codes for the station graph path block.
package gebp_pkg;

    localparam int IDX_W = 5;
    localparam int SLOTS = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_PATH   = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_SELF    = 3'd2;
    localparam logic [2:0] ST_EXISTS  = 3'd3;
    localparam logic [2:0] ST_NOEDGE  = 3'd4;
    localparam logic [2:0] ST_NOPATH  = 3'd5;

    // classified command from front to back
    typedef struct packed {
        logic [1:0]       req_type;
        logic             invalid;
        logic [IDX_W-1:0] src;
        logic [IDX_W-1:0] dst;
    } t_cmd;

endpackage

>>> src/gebp_if.sv
// Valid/ready channel interfaces for request and result words.
interface gebp_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [4:0] source_station;
    logic [4:0] target_station;
    modport source (output valid, req_type, source_station, target_station, input ready);
    modport sink (input valid, req_type, source_station, target_station, output ready);
endinterface

interface gebp_res_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [4:0] station;
    logic       last;
    modport source (output valid, status, station, last, input ready);
    modport sink (input valid, status, station, last, output ready);
endinterface

>>> src/gebp_front.sv
// Request intake: range check, drops unknown requests, feeds a two-entry queue.
module gebp_front
    import gebp_pkg::*;
#(
    parameter int MAX_STATIONS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [5:0]      i_count,
    gebp_req_if.sink        req,
    input  logic            i_pop,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd
);
    t_cmd       r_q [2];
    logic [1:0] r_cnt;
    logic [6:0] w_n;
    logic       w_push;
    t_cmd       w_cmd;

    // effective station count
    always_comb begin
        w_n = {1'b0, i_count};
        if (w_n > 7'(MAX_STATIONS)) w_n = 7'(MAX_STATIONS);
        if (w_n > 7'(SLOTS)) w_n = 7'(SLOTS);
    end

    always_comb begin
        w_cmd.req_type = req.req_type;
        w_cmd.src      = req.source_station;
        w_cmd.dst      = req.target_station;
        w_cmd.invalid  = ({2'b0, req.source_station} >= w_n) ||
                         ({2'b0, req.target_station} >= w_n);
    end

    assign req.ready   = (r_cnt != 2'd2);
    assign w_push      = req.valid && req.ready && (req.req_type != REQ_NONE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[0];

    // queue shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
        if (i_pop) begin
            r_q[0] <= r_q[1];
            if (w_push && r_cnt == 2'd1) r_q[0] <= w_cmd;
            if (w_push && r_cnt == 2'd2) r_q[1] <= w_cmd;
        end else if (w_push) begin
            if (r_cnt == 2'd0) r_q[0] <= w_cmd;
            else r_q[1] <= w_cmd;
        end
    end

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !w_push) |=> r_cnt == 2'd0) else $error("phantom push");
endmodule

>>> src/gebp_back.sv
// Command engine: edge updates, breadth-first search, path trace and emit.
module gebp_back
    import gebp_pkg::*;
#(
    parameter int MAX_STATIONS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [5:0]      i_count,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_pop,
    gebp_res_if.source      res
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEQ   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_TRACE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_ONE   = 3'd5;

    logic [2:0]       r_state;
    logic [31:0]      r_adj [SLOTS];
    logic [31:0]      r_vis;
    logic [IDX_W-1:0] r_sq [SLOTS];
    logic [5:0]       r_pred [SLOTS];
    logic [IDX_W-1:0] r_pb [SLOTS];
    logic [5:0]       r_head, r_tail, r_len;
    logic [IDX_W-1:0] r_cur, r_dst, r_i;
    logic [31:0]      r_nbr, r_lim;
    logic [5:0]       r_v;
    logic [6:0]       w_n;
    logic             r_ov;
    logic [2:0]       r_ost;
    logic [4:0]       r_ostn;
    logic             r_olast;

    always_comb begin
        w_n = {1'b0, i_count};
        if (w_n > 7'(MAX_STATIONS)) w_n = 7'(MAX_STATIONS);
        if (w_n > 7'(SLOTS)) w_n = 7'(SLOTS);
    end

    assign res.valid   = r_ov;
    assign res.status  = r_ost;
    assign res.station = r_ostn;
    assign res.last    = r_olast;
    wire w_free = !r_ov || res.ready;
    assign o_pop = (r_state == S_IDLE) && i_cmd_valid && w_free;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            for (int k = 0; k < SLOTS; k++) r_adj[k] <= '0;
        end else begin
            if (r_ov && res.ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_dst   <= i_cmd.dst;
                        r_ostn  <= '0;
                        r_olast <= 1'b1;
                        if (i_cmd.invalid) begin
                            r_ov <= 1'b1; r_ost <= ST_INVALID;
                        end else if (i_cmd.req_type == REQ_INSERT) begin
                            r_ov <= 1'b1;
                            if (i_cmd.src == i_cmd.dst) r_ost <= ST_SELF;
                            else if (r_adj[i_cmd.src][i_cmd.dst]) r_ost <= ST_EXISTS;
                            else begin
                                r_ost <= ST_OK;
                                r_adj[i_cmd.src][i_cmd.dst] <= 1'b1;
                                r_adj[i_cmd.dst][i_cmd.src] <= 1'b1;
                            end
                        end else if (i_cmd.req_type == REQ_REMOVE) begin
                            r_ov <= 1'b1;
                            if (!r_adj[i_cmd.src][i_cmd.dst]) r_ost <= ST_NOEDGE;
                            else begin
                                r_ost <= ST_OK;
                                r_adj[i_cmd.src][i_cmd.dst] <= 1'b0;
                                r_adj[i_cmd.dst][i_cmd.src] <= 1'b0;
                            end
                        end else begin
                            r_vis  <= 32'd1 << i_cmd.src;
                            for (int k = 0; k < SLOTS; k++) r_pred[k] <= 6'd63;
                            r_sq[0] <= i_cmd.src;
                            r_head <= '0;
                            r_tail <= 6'd1;
                            r_lim  <= (w_n >= 7'd32) ? '1 : ((32'd1 << w_n[4:0]) - 32'd1);
                            r_state <= S_DEQ;
                        end
                    end
                end
                S_DEQ: begin
                    if (r_head == r_tail) begin
                        if (w_free) begin
                            r_ov <= 1'b1; r_ost <= ST_NOPATH; r_ostn <= '0;
                            r_olast <= 1'b1; r_state <= S_IDLE;
                        end
                    end else begin
                        r_cur  <= r_sq[r_head[4:0]];
                        r_head <= r_head + 6'd1;
                        if (r_sq[r_head[4:0]] == r_dst) begin
                            r_v <= {1'b0, r_dst}; r_len <= '0; r_state <= S_TRACE;
                        end else begin
                            r_nbr <= r_adj[r_sq[r_head[4:0]]] & r_lim & ~r_vis;
                            r_i <= '0; r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_nbr[r_i]) begin
                        if (r_tail < 6'd32) begin
                            r_sq[r_tail[4:0]] <= r_i;
                            r_tail <= r_tail + 6'd1;
                        end
                        r_vis[r_i]  <= 1'b1;
                        r_pred[r_i] <= {1'b0, r_cur};
                    end
                    r_nbr[r_i] <= 1'b0;
                    if (r_i == 5'd31 || (r_nbr & ~(32'd1 << r_i)) == '0) r_state <= S_DEQ;
                    r_i <= r_i + 5'd1;
                end
                S_TRACE: begin
                    if (r_v == 6'd63 || r_len == 6'd32) r_state <= S_EMIT;
                    else begin
                        r_pb[r_len[4:0]] <= r_v[4:0];
                        r_len <= r_len + 6'd1;
                        r_v <= r_pred[r_v[4:0]];
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_ov    <= 1'b1;
                        r_ost   <= ST_OK;
                        r_ostn  <= r_pb[5'(r_len - 6'd1)];
                        r_olast <= (r_len == 6'd1);
                        r_len   <= r_len - 6'd1;
                        if (r_len == 6'd1) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !res.ready) |=> r_ov && $stable(r_ostn)) else $error("result lost");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == S_IDLE) else $error("pop while busy");
    a_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("queue head passed tail");
endmodule

>>> src/graph_edge_update_bfs_path.sv
// Station graph top level: request queue front end and search engine.
// Keeps a 32x32 undirected adjacency matrix in flip-flops, cleared by reset.
// Insert and remove answer with a single result word. A path search dequeues
// stations one by one and scans each one's neighbor bits up to the highest
// unvisited one, then traces predecessors back from the target and emits
// one result word per path station; the engine takes no new command until
// the last word of a search has been issued.
module graph_edge_update_bfs_path
    import gebp_pkg::*;
#(
    parameter int MAX_STATIONS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    gebp_req_if.sink   req,
    gebp_res_if.source res
);
    logic [5:0] r_count;
    logic       w_pop, w_cv;
    t_cmd       w_cmd;

    // station count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 6'd20;
        else if (i_cfg_we) r_count <= i_cfg_wdata;
    end

    gebp_front #(.MAX_STATIONS(MAX_STATIONS)) u_front (
        .i_clk, .i_rst_n, .i_count(r_count), .req,
        .i_pop(w_pop), .o_cmd_valid(w_cv), .o_cmd(w_cmd));

    gebp_back #(.MAX_STATIONS(MAX_STATIONS)) u_back (
        .i_clk, .i_rst_n, .i_count(r_count), .i_cmd_valid(w_cv),
        .i_cmd(w_cmd), .o_pop(w_pop), .res);
endmodule
